// ===== sv/idia_pkg.sv =====
// ----------------------------------------------------------------------------
// idia_pkg
// shared sizes, codes and bundle types of the indexed insert/delete array
// ----------------------------------------------------------------------------
package idia_pkg;

  localparam int CAPACITY    = 32;
  localparam int MAX_RESULTS = 32;

  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = 6;
  localparam int CMP_W    = (LEN_W > IDX_W) ? LEN_W : IDX_W;
  localparam int WORD_W   = 32;
  localparam int STAT_W   = 2;
  localparam int MODE_W   = 2;
  localparam int POS_W    = 5;
  localparam int LENO_W   = 6;
  localparam int CFG_W    = 6;
  localparam int DUMP_MAX = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic              clear_all;
    logic              we;
    logic              clr;
    logic [ADDR_W-1:0] waddr;
    word_t             wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    word_t             element;
    logic [POS_W-1:0]  position;
    logic [LENO_W-1:0] length_now;
    logic              last;
  } res_t;

endpackage

// ===== sv/indexed_insert_delete_array.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_delete_array
// ordered store of signed words with append, insert, remove and dump
//
//   port group  direction  handshake              payload
//   cfg         in         cfg_we_i               cfg_wdata_i (start length)
//   in          in         in_valid_i/in_stall_o  mode_i, index_i, value_i
//   out         out        out_valid_o/out_stall_i status_o, element_o,
//                                                 position_o, length_now_o,
//                                                 last_o
//
// append and any rejected item go straight to the result; insert and remove
// walk the shifted entries, and every entry moved costs a read and a write on
// the store (one write port, one registered read port).
// dump reads each entry emitted, then presents it (read latency of the
// store); a dump of an empty store returns the empty status.
// reset and a start length write clear all entries through per-entry valid
// bits at once: no clearing pass.
// an output stall holds the sequencer on its pending result; the next item
// is taken while the final result still waits in the output register.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array import idia_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [IDX_W-1:0]  index_i,
  input  word_t             value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output word_t             element_o,
  output logic [POS_W-1:0]  position_o,
  output logic [LENO_W-1:0] length_now_o,
  output logic              last_o
);

  mem_req_t mem_req;
  word_t    rdata;
  res_t     res;
  logic     out_ready, out_load;
  logic     out_valid_q, out_valid_d;
  res_t     out_q;

  idia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_ready_i (out_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rdata_i     (rdata)
  );

  idia_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // output register frees up in the same cycle its item is taken
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign out_load    = res.valid && out_ready;
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign element_o    = out_q.element;
  assign position_o   = out_q.position;
  assign length_now_o = out_q.length_now;
  assign last_o       = out_q.last;

endmodule

// ===== sv/idia_mem.sv =====
// ----------------------------------------------------------------------------
// idia_mem
// entry store: one write and one registered read port, per-entry valid bits
// ----------------------------------------------------------------------------
module idia_mem import idia_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output word_t    rdata_o
);

  word_t              mem [CAPACITY];
  logic [CAPACITY-1:0] valid_q;
  word_t              rdata_q;
  logic               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // an entry never written since the last clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.clear_all) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end else if (req_i.clr) begin
        valid_q[req_i.waddr] <= 1'b0;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== sv/idia_ctrl.sv =====
// ----------------------------------------------------------------------------
// idia_ctrl
// sequencer: decodes an item, walks the store for shifts and dumps
// ----------------------------------------------------------------------------
module idia_ctrl import idia_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [IDX_W-1:0]  index_i,
  input  word_t             value_i,
  input  logic              out_ready_i,
  output res_t              res_o,
  output mem_req_t          mem_req_o,
  input  word_t             rdata_i
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD      = 3'd1;
  localparam logic [2:0] S_WR      = 3'd2;
  localparam logic [2:0] S_PUT     = 3'd3;
  localparam logic [2:0] S_FIN     = 3'd4;
  localparam logic [2:0] S_RESULT  = 3'd5;
  localparam logic [2:0] S_DUMP_RD = 3'd6;
  localparam logic [2:0] S_DUMP_WR = 3'd7;

  logic [2:0]        state_q, state_d;
  logic              ins_q, ins_d;
  logic [LEN_W-1:0]  ptr_q, ptr_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  word_t             val_q, val_d;
  logic [STAT_W-1:0] stat_q, stat_d;

  logic [LEN_W-1:0] ptr_inc, ptr_dec, len_inc, len_dec, dump_n;
  logic [CMP_W-1:0] idx_c, len_c;
  logic             full, dump_last;

  assign ptr_inc   = ptr_q + LEN_W'(1);
  assign ptr_dec   = ptr_q - LEN_W'(1);
  assign len_inc   = len_q + LEN_W'(1);
  assign len_dec   = len_q - LEN_W'(1);
  assign idx_c     = CMP_W'(index_i);
  assign len_c     = CMP_W'(len_q);
  assign full      = (len_q >= LEN_W'(CAPACITY));
  assign dump_n    = (len_q > LEN_W'(DUMP_MAX)) ? LEN_W'(DUMP_MAX) : len_q;
  assign dump_last = (ptr_inc == dump_n);

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    ins_d   = ins_q;
    ptr_d   = ptr_q;
    len_d   = len_q;
    idx_d   = idx_q;
    val_d   = val_q;
    stat_d  = stat_q;

    mem_req_o           = '0;
    mem_req_o.clear_all = cfg_we_i;

    res_o            = '0;
    res_o.length_now = LENO_W'(len_q);

    if (cfg_we_i) begin
      len_d = (CMP_W'(cfg_wdata_i) > CMP_W'(CAPACITY)) ? LEN_W'(CAPACITY)
                                                      : LEN_W'(cfg_wdata_i);
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d   = value_i;
          idx_d   = ADDR_W'(index_i);
          stat_d  = ST_OK;
          state_d = S_RESULT;
          unique case (mode_i)
            MODE_APPEND: begin
              if (full) begin
                stat_d = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = len_q[ADDR_W-1:0];
                mem_req_o.wdata = value_i;
                len_d           = len_inc;
              end
            end
            MODE_INSERT: begin
              if (idx_c > len_c) begin
                stat_d = ST_BAD_INDEX;
              end else if (full) begin
                stat_d = ST_FULL;
              end else begin
                ins_d   = 1'b1;
                ptr_d   = len_q;
                state_d = S_RD;
              end
            end
            MODE_REMOVE: begin
              if (idx_c >= len_c) begin
                stat_d = ST_BAD_INDEX;
              end else begin
                ins_d   = 1'b0;
                ptr_d   = LEN_W'(index_i);
                state_d = S_RD;
              end
            end
            MODE_DUMP: begin
              if (dump_n == '0) begin
                stat_d = ST_EMPTY;
              end else begin
                ptr_d   = '0;
                state_d = S_DUMP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      // shift loop: insert walks down from the top, remove walks up
      S_RD: begin
        if (ins_q) begin
          if (ptr_q > LEN_W'(idx_q)) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ptr_dec[ADDR_W-1:0];
            state_d         = S_WR;
          end else begin
            state_d = S_PUT;
          end
        end else begin
          if (ptr_inc < len_q) begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = ptr_inc[ADDR_W-1:0];
            state_d         = S_WR;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q[ADDR_W-1:0];
        mem_req_o.wdata = rdata_i;
        ptr_d           = ins_q ? ptr_dec : ptr_inc;
        state_d         = S_RD;
      end
      S_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q;
        mem_req_o.wdata = val_q;
        len_d           = len_inc;
        state_d         = S_RESULT;
      end
      // vacated top cell goes back to zero
      S_FIN: begin
        mem_req_o.clr   = 1'b1;
        mem_req_o.waddr = len_dec[ADDR_W-1:0];
        len_d           = len_dec;
        state_d         = S_RESULT;
      end
      S_RESULT: begin
        res_o.valid  = 1'b1;
        res_o.status = stat_q;
        res_o.last   = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = ptr_q[ADDR_W-1:0];
        state_d         = S_DUMP_WR;
      end
      S_DUMP_WR: begin
        res_o.valid    = 1'b1;
        res_o.status   = ST_OK;
        res_o.element  = rdata_i;
        res_o.position = POS_W'(ptr_q);
        res_o.last     = dump_last;
        if (out_ready_i) begin
          ptr_d   = ptr_inc;
          state_d = dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ins_q   <= 1'b0;
      ptr_q   <= '0;
      len_q   <= '0;
      stat_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      ins_q   <= ins_d;
      ptr_q   <= ptr_d;
      len_q   <= len_d;
      stat_q  <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
  end

endmodule
